/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks in the LFO RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MSL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* rtl/msl_pkg.sv */
// ----------------------------------------------------------------------------
// msl_pkg
// Types, constants and table functions shared by the LFO modules.
// ----------------------------------------------------------------------------
`default_nettype none

package msl_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Shared multiply-add unit: r = a * b + c.
	localparam int MAC_A_W = 33;
	localparam int MAC_B_W = 18;
	localparam int MAC_C_W = 48;
	localparam int MAC_R_W = 51;

	localparam logic [12:0] MAX_BLOCK   = 13'd4096;
	localparam logic [16:0] FULL_DEPTH  = 17'd65536;
	localparam logic [15:0] RAMP_RESET  = 16'd2400;
	localparam logic [31:0] LFSR_MASK   = 32'h8020_0003;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [2:0] {
		REG_PHASE_STEP  = 3'd0,
		REG_WAVE_SHAPE  = 3'd1,
		REG_DEPTH_GOAL  = 3'd2,
		REG_RAMP_LENGTH = 3'd3,
		REG_NOISE_SEED  = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		SHAPE_SINE     = 3'd0,
		SHAPE_TRIANGLE = 3'd1,
		SHAPE_SAW      = 3'd2,
		SHAPE_SQUARE   = 3'd3,
		SHAPE_HOLD     = 3'd4
	} shape_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_DIV,
		ST_SLOPE,
		ST_PHASE,
		ST_DRAW,
		ST_DEPTH,
		ST_SHAPE,
		ST_MULT
	} state_t;

	typedef struct packed {
		logic [12:0] sample_count;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] lfo_value;
		logic               cycle_wrapped;
	} out_item_t;

	// One Galois step of the noise generator.
	function automatic logic [31:0] lfsr_step(input logic [31:0] w);
		logic [31:0] nxt;
		nxt = w >> 1;
		if (w[0]) begin
			nxt = nxt ^ LFSR_MASK;
		end
		return nxt;
	endfunction

	// Quarter-wave table entry: Q30 Taylor series of the angle, scaled to Q15.
	// Evaluated at elaboration only.
	function automatic logic [15:0] sine_q15(input logic [63:0] ang);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		x2   = (ang * ang) >> 30;
		term = ang;
		sum  = ang;
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - term;
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + term;
		if (sum > (64'd1 << 30)) begin
			sum = 64'd1 << 30;
		end
		v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[15:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/msl_stream_if.sv */
// ----------------------------------------------------------------------------
// msl_stream_if
// Valid/ready channel carrying one item of a packed payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface msl_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/multi_shape_lfo_top.sv */
// ----------------------------------------------------------------------------
// multi_shape_lfo_top
// Block-advanced low-frequency oscillator with five shapes and a depth ramp.
// ----------------------------------------------------------------------------
// Usage:
// Each input item carries sample_count, the number of audio samples that the
// oscillator advances by. For every input item exactly one output item leaves
// with the scaled oscillator value and a flag that tells whether the phase
// wrapped during the advance.
// Configuration is written through cfg_we / cfg_idx / cfg_data while no item
// is in flight. Writing the noise seed reloads the random generator at once.
// An item passes through the phase, depth, shape and multiply steps, and the
// result is loaded into the output register as the sequencer returns to idle,
// ready for the next item. A change of the depth target adds a difference
// step, the slope division (one quotient bit a cycle over 32 bits) and a slope
// step first, and a phase wrap adds the noise draw. One multiply-add unit does
// the difference, division, phase, depth and multiply steps, one at a time.
// in_ch.ready is high only while the sequencer is idle. The result sits in an
// output register, so a new item is accepted while the previous result still
// waits; if the receiver stalls, the sequencer holds its last step until the
// register frees up.
// Reset clears the phase, the depth ramp and the held random value, sets the
// ramp length to 2400 samples and seeds the random generator with 1. The sine
// table is constant logic and needs no fill after reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module multi_shape_lfo_top
	import msl_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	msl_stream_if.sink                 in_ch,
	msl_stream_if.source               out_ch
);

	// The table index takes the top bits of the quarter-cycle phase.
	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
	localparam int SP_W  = 30 + IDX_W;

	// Configuration registers.
	logic [30:0] phase_step_q;
	logic [2:0]  wave_shape_q;
	logic [16:0] depth_goal_q;
	logic [15:0] ramp_length_q;

	// Oscillator state.
	logic [31:0]        phase_q;
	logic signed [15:0] held_q;
	logic [31:0]        lfsr_q;
	logic [31:0]        depth_q;
	logic signed [32:0] slope_q;
	logic [15:0]        ramp_left_q;
	logic [16:0]        goal_seen_q;

	// Per-item working registers.
	state_t             state_q;
	state_t             state_d;
	logic [12:0]        n_q;
	logic [31:0]        mag_q;
	logic               neg_q;
	logic [15:0]        rem_q;
	logic [4:0]         cnt_q;
	logic               wrap_q;
	logic signed [16:0] shape_q;

	logic      out_valid_q;
	out_item_t out_data_q;
	logic      out_load;

	logic [12:0] n_clamp;
	logic [16:0] goal_clamp;
	logic        goal_change;

	logic signed [MAC_A_W-1:0] mac_a;
	logic signed [MAC_B_W-1:0] mac_b;
	logic signed [MAC_C_W-1:0] mac_c;
	logic signed [MAC_R_W-1:0] mac_r;
	logic signed [MAC_R_W-1:0] mac_neg;

	logic [16:0] rem_shift;
	logic        trial_ok;
	logic        wrap_now;
	logic [31:0] lfsr_next;

	logic [15:0]        sine_rom [SINE_TABLE_DEPTH];
	logic [SP_W-1:0]    sine_prod;
	logic [IDX_W-1:0]   sine_idx;
	logic [IDX_W-1:0]   sine_mir;
	logic [15:0]        sine_mag;
	logic [31:0]        tri_dist;
	logic signed [17:0] tri_val;
	logic signed [16:0] shape_val;

	logic        sat_hi;
	logic        sat_lo;
	logic signed [15:0] lfo_res;

	// Quarter-wave sine table, built at elaboration.
	for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
		localparam logic [63:0] ANG = (HALF_PI_Q30 * 64'(gi)) / 64'(SINE_TABLE_DEPTH);
		assign sine_rom[gi] = sine_q15(ANG);
	end

	// Block length above the maximum acts as the maximum; the depth target is
	// limited to full scale.
	assign n_clamp     = (in_ch.data.sample_count > MAX_BLOCK) ? MAX_BLOCK
		: in_ch.data.sample_count;
	assign goal_clamp  = (depth_goal_q > FULL_DEPTH) ? FULL_DEPTH : depth_goal_q;
	assign goal_change = (goal_clamp != goal_seen_q);

	// Division step: shift in the next dividend bit and try to subtract.
	assign rem_shift = {rem_q, mag_q[31]};
	assign trial_ok  = !mac_r[MAC_R_W-1];
	assign mac_neg   = -mac_r;
	assign wrap_now  = (mac_r[MAC_R_W-1:32] != '0);
	assign lfsr_next = lfsr_step(lfsr_q);

	// Operand selection for the shared multiply-add unit.
	always_comb begin
		mac_a = '0;
		mac_b = '0;
		mac_c = '0;
		unique case (state_q)
			ST_DIFF: begin
				// goal * 2^15 - depth
				mac_a = $signed({1'b0, depth_q});
				mac_b = -MAC_B_W'(1);
				mac_c = $signed(MAC_C_W'({goal_seen_q, 15'b0}));
			end
			ST_DIV: begin
				mac_a = $signed(MAC_A_W'(ramp_length_q));
				mac_b = -MAC_B_W'(1);
				mac_c = $signed(MAC_C_W'(rem_shift));
			end
			ST_PHASE: begin
				mac_a = $signed(MAC_A_W'(phase_step_q));
				mac_b = $signed(MAC_B_W'(n_q));
				mac_c = $signed(MAC_C_W'(phase_q));
			end
			ST_DEPTH: begin
				mac_a = slope_q;
				mac_b = $signed(MAC_B_W'(n_q));
				mac_c = $signed(MAC_C_W'(depth_q));
			end
			ST_MULT: begin
				mac_a = MAC_A_W'(shape_q);
				mac_b = $signed({1'b0, depth_q[31:15]});
			end
			default: begin
			end
		endcase
	end

	msl_mac u_mac (
		.a (mac_a),
		.b (mac_b),
		.c (mac_c),
		.r (mac_r)
	);

	// Shape of the current phase.
	always_comb begin
		sine_prod = SP_W'(phase_q[29:0]) * SP_W'(SINE_TABLE_DEPTH);
		sine_idx  = sine_prod[30 +: IDX_W];
		sine_mir  = IDX_W'(SINE_TABLE_DEPTH) - sine_idx;
		if (phase_q[30]) begin
			// Falling quarter: mirror the index; the peak is not in the table.
			sine_mag = (sine_idx == '0) ? 16'd32767 : sine_rom[sine_mir];
		end else begin
			sine_mag = sine_rom[sine_idx];
		end
		tri_dist = phase_q[31] ? (phase_q - 32'h8000_0000) : (32'h8000_0000 - phase_q);
		tri_val  = $signed({1'b0, tri_dist[31:15]}) - 18'sd32768;
		unique case (wave_shape_q)
			SHAPE_SINE: begin
				shape_val = phase_q[31] ? -$signed({1'b0, sine_mag})
					: $signed({1'b0, sine_mag});
			end
			SHAPE_TRIANGLE: shape_val = tri_val[16:0];
			SHAPE_SAW:      shape_val = $signed({1'b0, phase_q[31:16]}) - 17'sd32768;
			SHAPE_SQUARE:   shape_val = phase_q[31] ? -17'sd32768 : 17'sd32768;
			SHAPE_HOLD:     shape_val = 17'(held_q);
			default:        shape_val = '0;
		endcase
	end

	// Floor by 2^16 and saturate to Q1.15.
	assign sat_hi  = !mac_r[MAC_R_W-1] && (mac_r[MAC_R_W-2:31] != '0);
	assign sat_lo  = mac_r[MAC_R_W-1] && (mac_r[MAC_R_W-2:31] != '1);
	assign lfo_res = sat_hi ? 16'sh7FFF : (sat_lo ? -16'sh8000 : mac_r[31:16]);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		out_load    = 1'b0;
		in_ch.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					state_d = (goal_change && (ramp_length_q != '0)) ? ST_DIFF : ST_PHASE;
				end
			end
			ST_DIFF:  state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == 5'd31) begin
					state_d = ST_SLOPE;
				end
			end
			ST_SLOPE: state_d = ST_PHASE;
			ST_PHASE: state_d = wrap_now ? ST_DRAW : ST_DEPTH;
			ST_DRAW: begin
				if (cnt_q == 5'd15) begin
					state_d = ST_DEPTH;
				end
			end
			ST_DEPTH: state_d = ST_SHAPE;
			ST_SHAPE: state_d = ST_MULT;
			ST_MULT: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q  <= '0;
			wave_shape_q  <= '0;
			depth_goal_q  <= '0;
			ramp_length_q <= RAMP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_PHASE_STEP:  phase_step_q  <= cfg_data[30:0];
				REG_WAVE_SHAPE:  wave_shape_q  <= cfg_data[2:0];
				REG_DEPTH_GOAL:  depth_goal_q  <= cfg_data[16:0];
				REG_RAMP_LENGTH: ramp_length_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Oscillator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			held_q      <= '0;
			lfsr_q      <= 32'd1;
			depth_q     <= '0;
			slope_q     <= '0;
			ramp_left_q <= '0;
			goal_seen_q <= '0;
		end else begin
			if (cfg_we && (cfg_idx == REG_NOISE_SEED)) begin
				// A zero seed would lock the generator up.
				lfsr_q <= (cfg_data == '0) ? 32'd1 : cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && goal_change) begin
						goal_seen_q <= goal_clamp;
						if (ramp_length_q == '0) begin
							depth_q     <= {goal_clamp, 15'b0};
							slope_q     <= '0;
							ramp_left_q <= '0;
						end
					end
				end
				ST_SLOPE: begin
					slope_q     <= neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
					ramp_left_q <= ramp_length_q;
				end
				ST_PHASE: phase_q <= mac_r[31:0];
				ST_DRAW: begin
					lfsr_q <= lfsr_next;
					if (cnt_q == 5'd15) begin
						held_q <= lfsr_next[31:16];
					end
				end
				ST_DEPTH: begin
					if (16'(n_q) >= ramp_left_q) begin
						depth_q     <= {goal_seen_q, 15'b0};
						ramp_left_q <= '0;
					end else begin
						depth_q     <= mac_r[31:0];
						ramp_left_q <= ramp_left_q - 16'(n_q);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers of the current item.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					n_q <= n_clamp;
				end
			end
			ST_DIFF: begin
				neg_q <= mac_r[MAC_R_W-1];
				mag_q <= mac_r[MAC_R_W-1] ? mac_neg[31:0] : mac_r[31:0];
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= trial_ok ? mac_r[15:0] : rem_shift[15:0];
				mag_q <= {mag_q[30:0], trial_ok};
				cnt_q <= cnt_q + 5'd1;
			end
			ST_PHASE: begin
				wrap_q <= wrap_now;
				cnt_q  <= '0;
			end
			ST_DRAW:  cnt_q   <= cnt_q + 5'd1;
			ST_SHAPE: shape_q <= shape_val;
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q.lfo_value     <= lfo_res;
			out_data_q.cycle_wrapped <= wrap_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

	// An accepted item always starts the sequence.
	`MSL_ASSERT_NXT(a_accept_starts, clk, arst_n, in_ch.valid && in_ch.ready, state_q != ST_IDLE)
	// The held random value only moves at the end of a noise draw.
	`MSL_ASSERT_IMP(a_hold_from_draw, clk, arst_n, !$stable(held_q), $past(state_q) == ST_DRAW)
	// With no ramp left the depth sits exactly on the last target seen.
	`MSL_ASSERT_IMP(a_depth_settled, clk, arst_n, (state_q == ST_IDLE) && (ramp_left_q == '0),
		depth_q == {goal_seen_q, 15'b0})
	// The slope division never runs with a zero divisor.
	`MSL_ASSERT_IMP(a_div_nonzero, clk, arst_n, state_q == ST_DIV, ramp_length_q != '0)

endmodule

`default_nettype wire

/* rtl/msl_mac.sv */
// ----------------------------------------------------------------------------
// msl_mac
// Shared signed multiply-add unit used by most steps of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module msl_mac
	import msl_pkg::*;
(
	input  wire logic signed [MAC_A_W-1:0] a,
	input  wire logic signed [MAC_B_W-1:0] b,
	input  wire logic signed [MAC_C_W-1:0] c,
	output logic signed [MAC_R_W-1:0]      r
);

	logic signed [MAC_R_W-1:0] prod;

	assign prod = MAC_R_W'(a) * MAC_R_W'(b);
	assign r    = prod + MAC_R_W'(c);

endmodule

`default_nettype wire

/* test/tb_multi_shape_lfo_top.sv */
// ----------------------------------------------------------------------------
// tb_multi_shape_lfo_top
// Self-checking bench for the block-advanced LFO. Every accepted item runs
// through a local predictor, and each output item is compared with it in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_multi_shape_lfo_top;
	import msl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SINE_DEPTH     = 256;
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 150;
	localparam int RX_HOLD_CYCLES = 300;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	msl_stream_if #(.T(in_item_t))  in_ch ();
	msl_stream_if #(.T(out_item_t)) out_ch ();

	multi_shape_lfo_top #(
		.SINE_TABLE_DEPTH(SINE_DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state. The register copies track what has been written to
	// the block, and the oscillator state follows every accepted item.
	// ------------------------------------------------------------------
	logic [30:0]        step_reg;
	logic [2:0]         shape_reg;
	logic [16:0]        goal_reg;
	logic [15:0]        ramp_reg;

	logic [31:0]        phase_acc;
	logic signed [15:0] noise_hold;
	logic [31:0]        noise_lfsr;
	logic [31:0]        depth_now;
	longint             depth_slope;
	logic [15:0]        ramp_left;
	logic [16:0]        goal_seen;
	logic [15:0]        sine_table [0:SINE_DEPTH-1];

	// Items waiting to be offered, and the outputs the block still owes us.
	in_item_t  queued_counts[$];
	out_item_t awaited_outputs[$];
	out_item_t due_item;

	int   mismatch_count = 0;
	logic in_taken = 1'b0;
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	int   rx_hold_asked = 0;
	int   rx_hold_granted = 0;
	int   rx_hold_left = 0;

	// Q30 sine of a Q30 angle from a Taylor series through the x^13 term.
	function automatic logic [63:0] taylor_sin_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] acc;
		x2 = (x * x) >> 30;
		term = x;
		acc = x;
		for (int k = 1; k <= 6; k++) begin
			term = ((term * x2) >> 30) / 64'(2 * k * (2 * k + 1));
			if (k % 2 == 1) begin
				acc = acc - term;
			end else begin
				acc = acc + term;
			end
		end
		if (acc > (64'd1 << 30)) begin
			acc = 64'd1 << 30;
		end
		return acc;
	endfunction

	function automatic int sine_of(input logic [31:0] ph);
		logic [1:0] quad;
		int         idx;
		int         mag;
		quad = ph[31:30];
		idx = int'((64'(ph[29:0]) * SINE_DEPTH) >> 30);
		// Odd quadrants run the table backwards; the mirror of entry zero is the peak.
		if (quad[0]) begin
			mag = (idx == 0) ? 32767 : int'(sine_table[SINE_DEPTH - idx]);
		end else begin
			mag = int'(sine_table[idx]);
		end
		return quad[1] ? -mag : mag;
	endfunction

	function automatic int shape_of(input logic [31:0] ph);
		logic [31:0] tri_span;
		case (shape_reg)
			SHAPE_SINE: return sine_of(ph);
			SHAPE_TRIANGLE: begin
				tri_span = (ph >= 32'h8000_0000) ? ph - 32'h8000_0000 : 32'h8000_0000 - ph;
				return int'(tri_span >> 15) - 32768;
			end
			SHAPE_SAW: return int'(ph >> 16) - 32768;
			SHAPE_SQUARE: return (ph < 32'h8000_0000) ? 32768 : -32768;
			SHAPE_HOLD: return int'(noise_hold);
			default: return 0;
		endcase
	endfunction

	// Advances the oscillator by one block and returns the output item it owes.
	function automatic out_item_t lfo_advance(input logic [12:0] raw_count);
		logic [12:0] n;
		logic [16:0] goal;
		logic [63:0] sum;
		logic        wrapped;
		logic        fb;
		longint      diff;
		longint      prod;
		longint      res;
		out_item_t   r;
		n = (raw_count > MAX_BLOCK) ? MAX_BLOCK : raw_count;
		goal = (goal_reg > FULL_DEPTH) ? FULL_DEPTH : goal_reg;

		// A new target restarts the ramp from the depth now; a zero ramp jumps to it.
		if (goal != goal_seen) begin
			goal_seen = goal;
			if (ramp_reg == 16'd0) begin
				depth_now = {goal, 15'd0};
				depth_slope = 0;
				ramp_left = 16'd0;
			end else begin
				diff = longint'({32'd0, goal, 15'd0}) - longint'({32'd0, depth_now});
				depth_slope = diff / longint'({48'd0, ramp_reg});
				ramp_left = ramp_reg;
			end
		end

		sum = 64'(phase_acc) + 64'(step_reg) * 64'(n);
		wrapped = |sum[63:32];
		phase_acc = sum[31:0];
		// However many cycles the block spans, a wrap draws one new held value.
		if (wrapped) begin
			for (int i = 0; i < 16; i++) begin
				fb = noise_lfsr[0];
				noise_lfsr = noise_lfsr >> 1;
				if (fb) begin
					noise_lfsr = noise_lfsr ^ LFSR_MASK;
				end
			end
			noise_hold = noise_lfsr[31:16];
		end

		if (16'(n) >= ramp_left) begin
			depth_now = {goal_seen, 15'd0};
			ramp_left = 16'd0;
		end else begin
			depth_now = 32'(longint'({32'd0, depth_now}) + depth_slope * longint'({51'd0, n}));
			ramp_left = ramp_left - 16'(n);
		end

		prod = longint'(shape_of(phase_acc)) * longint'({47'd0, depth_now[31:15]});
		res = prod >>> 16;
		if (res > 32767) begin
			res = 32767;
		end else if (res < -32768) begin
			res = -32768;
		end
		r.lfo_value = res[15:0];
		r.cycle_wrapped = wrapped;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Sender. A new item is chosen only when the previous one was taken
	// or nothing is on offer, so valid never drops with an item pending.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || in_taken) begin
			if (queued_counts.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				in_ch.data <= queued_counts.pop_front();
				in_ch.valid <= 1'b1;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver. A hold request from the stimulus turns into a long stall that
	// this process counts down itself; otherwise ready is random.
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			out_ch.ready <= 1'b0;
			rx_hold_left <= rx_hold_left - 1;
		end else if (rx_hold_asked != rx_hold_granted) begin
			rx_hold_granted <= rx_hold_asked;
			rx_hold_left <= RX_HOLD_CYCLES;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Monitor. Accepted inputs are predicted at the edge that takes them, and
	// accepted outputs are checked against the oldest prediction.
	always @(posedge clk) begin
		in_taken <= in_ch.valid && in_ch.ready;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			awaited_outputs.push_back(lfo_advance(in_ch.data.sample_count));
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (awaited_outputs.size() == 0) begin
				$error("output item with none expected: lfo_value %0d, cycle_wrapped %0b",
					out_ch.data.lfo_value, out_ch.data.cycle_wrapped);
				mismatch_count++;
			end else begin
				due_item = awaited_outputs.pop_front();
				if (out_ch.data.lfo_value !== due_item.lfo_value) begin
					$error("lfo_value: expected %0d, got %0d",
						due_item.lfo_value, out_ch.data.lfo_value);
					mismatch_count++;
				end
				if (out_ch.data.cycle_wrapped !== due_item.cycle_wrapped) begin
					$error("cycle_wrapped: expected %0b, got %0b",
						due_item.cycle_wrapped, out_ch.data.cycle_wrapped);
					mismatch_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------
	task automatic offer(input logic [12:0] n);
		queued_counts.push_back(in_item_t'(n));
	endtask

	// Waits until every queued item has been taken and answered.
	task automatic wait_answered();
		while (queued_counts.size() != 0 || in_ch.valid || awaited_outputs.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Every item yields a result, so once all are answered the block is idle;
	// a short pad covers the output register letting go.
	task automatic quiesce();
		wait_answered();
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PHASE_STEP: step_reg = val[30:0];
			REG_WAVE_SHAPE: shape_reg = val[2:0];
			REG_DEPTH_GOAL: goal_reg = val[16:0];
			REG_RAMP_LENGTH: ramp_reg = val[15:0];
			REG_NOISE_SEED: begin
				noise_lfsr = (val == 32'd0) ? 32'd1 : val;
			end
			default: ;
		endcase
	endtask

	// Block lengths lean short so that ramps take many items to finish,
	// with some full-width counts that exercise the clamp.
	function automatic logic [12:0] pick_count();
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: return 13'($urandom_range(64, 1));
			6, 7: return 13'($urandom_range(4096, 0));
			8: return 13'($urandom_range(8191, 0));
			default: return ($urandom_range(1) != 0) ? MAX_BLOCK : 13'd0;
		endcase
	endfunction

	task automatic setup_phase(input int ph);
		logic [31:0] val;
		case ($urandom_range(5))
			0: val = $urandom_range(1 << 16, 0);
			1: val = $urandom_range(1 << 22, 0);
			2: val = $urandom;
			3: val = 32'h7FFF_FFFF;
			4: val = 32'd0;
			default: val = $urandom_range(1 << 26, 0);
		endcase
		write_reg(REG_PHASE_STEP, val);
		// Walk through all eight shape codes, with noise in the unused bits.
		val = $urandom;
		val[2:0] = 3'(ph);
		write_reg(REG_WAVE_SHAPE, val);
		case ($urandom_range(4))
			0: val = 32'd0;
			1: val = 32'(FULL_DEPTH);
			2: val = $urandom_range(131071, 0);
			3: val = $urandom;
			default: val = $urandom_range(4096, 0);
		endcase
		write_reg(REG_DEPTH_GOAL, val);
		case ($urandom_range(4))
			0: val = 32'd0;
			1: val = 32'd1;
			2: val = 32'd65535;
			3: val = $urandom_range(3000, 1);
			default: val = $urandom;
		endcase
		write_reg(REG_RAMP_LENGTH, val);
		if ($urandom_range(2) == 0) begin
			write_reg(REG_NOISE_SEED, ($urandom_range(3) == 0) ? 32'd0 : $urandom);
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		logic [63:0] ang;
		logic [63:0] v;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_PHASE_STEP;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;

		// Predictor starts from the documented reset state.
		step_reg = '0;
		shape_reg = SHAPE_SINE;
		goal_reg = '0;
		ramp_reg = RAMP_RESET;
		phase_acc = '0;
		noise_hold = '0;
		noise_lfsr = 32'd1;
		depth_now = '0;
		depth_slope = 0;
		ramp_left = '0;
		goal_seen = '0;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			ang = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_DEPTH);
			v = (taylor_sin_q30(ang) * 64'd32767 + (64'd1 << 29)) >> 30;
			sine_table[i] = (v > 64'd32767) ? 16'd32767 : v[15:0];
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 12;
		rx_idle_pct = 78;

		// Untouched registers: no phase step, so the phase sits at zero,
		// including for an empty block and for the largest block.
		offer(13'd1);
		offer(MAX_BLOCK);
		offer(13'd0);
		quiesce();

		// Fastest step on a saw at full depth with an instant jump. Long
		// blocks wrap many times yet flag once; counts past the block limit
		// act as the limit.
		write_reg(REG_PHASE_STEP, 32'h7FFF_FFFF);
		write_reg(REG_WAVE_SHAPE, 32'(SHAPE_SAW));
		write_reg(REG_DEPTH_GOAL, 32'(FULL_DEPTH));
		write_reg(REG_RAMP_LENGTH, 32'd0);
		offer(13'd0);
		offer(13'd1);
		offer(13'd8191);
		offer(13'd4097);
		offer(MAX_BLOCK);
		quiesce();

		// A target above full scale acts as full scale, so no ramp starts.
		// Dropping it to zero then runs a one-sample ramp.
		write_reg(REG_RAMP_LENGTH, 32'd1);
		write_reg(REG_DEPTH_GOAL, 32'h0001_FFFF);
		offer(13'd3);
		quiesce();
		write_reg(REG_DEPTH_GOAL, 32'd0);
		offer(13'd1);
		quiesce();

		// Every shape code once at full depth; the square saturates, and the
		// three undefined codes give a flat zero.
		write_reg(REG_RAMP_LENGTH, 32'd0);
		write_reg(REG_DEPTH_GOAL, 32'(FULL_DEPTH));
		write_reg(REG_PHASE_STEP, 32'h1234_5679);
		for (int s = 0; s < (1 << 3); s++) begin
			write_reg(REG_WAVE_SHAPE, 32'(s));
			offer(13'd1000);
			quiesce();
		end

		// A zero seed falls back to one; the held value then follows each
		// wrap while the depth ramps down over the longest ramp.
		write_reg(REG_NOISE_SEED, 32'd0);
		write_reg(REG_WAVE_SHAPE, 32'(SHAPE_HOLD));
		write_reg(REG_RAMP_LENGTH, 32'd65535);
		write_reg(REG_DEPTH_GOAL, 32'd0);
		offer(MAX_BLOCK);
		offer(MAX_BLOCK);
		quiesce();

		// Writes to indexes past the last register must change nothing.
		for (int r = int'(REG_NOISE_SEED) + 1; r < (1 << CFG_IDX_W); r++) begin
			write_reg(CFG_IDX_W'(r), $urandom);
		end
		offer(13'd77);
		quiesce();

		// Random phases: a fresh register setting each, with the idle
		// pattern moving from a slow receiver to a slow sender to none.
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < PHASES / 3) begin
				tx_idle_pct = 12;
				rx_idle_pct = 78;
			end else if (ph < 2 * PHASES / 3) begin
				tx_idle_pct = 78;
				rx_idle_pct = 12;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			setup_phase(ph);

			if (ph == PHASES - 3) begin
				// Stall the receiver for a long stretch while items keep
				// coming, so the block backs up and drops its input ready.
				rx_hold_asked++;
				for (int i = 0; i < PHASE_ITEMS; i++) begin
					offer(pick_count());
				end
			end else if (ph == PHASES - 2) begin
				// Let the sender go quiet mid-phase until every result is in.
				for (int i = 0; i < PHASE_ITEMS / 2; i++) begin
					offer(pick_count());
				end
				wait_answered();
				for (int i = PHASE_ITEMS / 2; i < PHASE_ITEMS; i++) begin
					offer(pick_count());
				end
			end else begin
				for (int i = 0; i < PHASE_ITEMS; i++) begin
					offer(pick_count());
				end
			end
			quiesce();
		end

		wait_answered();
		repeat (60) @(posedge clk);
		if (mismatch_count == 0 && awaited_outputs.size() == 0) begin
			$display("** multi_shape_lfo_top: PASSED **");
		end else begin
			$display("** multi_shape_lfo_top: FAILED **");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#8000000;
		$display("** multi_shape_lfo_top: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
